FILE: hdl/tseb_pkg.sv
// ----------------------------------------------------------------------------
// tseb_pkg
// Shared widths, operation and status codes and default sizes for the
// timestamp-sorted event buffer.
// ----------------------------------------------------------------------------
package tseb_pkg;

  localparam int OP_W     = 2;
  localparam int TIME_W   = 64;
  localparam int TAG_W    = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int DEPTH_DEF     = 64;
  localparam int TAG_WIDTH_DEF = 32;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd2;

  typedef logic signed [TIME_W-1:0] time_val_t;

endpackage

FILE: hdl/tseb_req_if.sv
// ----------------------------------------------------------------------------
// tseb_req_if
// Request channel: valid/ready handshake with operation, event and index.
// ----------------------------------------------------------------------------
interface tseb_req_if import tseb_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  time_val_t           event_time;
  logic [TAG_W-1:0]    event_tag;
  logic [INDEX_W-1:0]  read_index;

  modport source (output valid, op, event_time, event_tag, read_index, input ready);
  modport sink   (input valid, op, event_time, event_tag, read_index, output ready);

endinterface

FILE: hdl/tseb_rsp_if.sv
// ----------------------------------------------------------------------------
// tseb_rsp_if
// Result channel: valid/ready handshake with status, count and read entry.
// ----------------------------------------------------------------------------
interface tseb_rsp_if import tseb_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  time_val_t           read_time;
  logic [TAG_W-1:0]    read_tag;

  modport source (output valid, status, entry_count, read_time, read_tag, input ready);
  modport sink   (input valid, status, entry_count, read_time, read_tag, output ready);

endinterface

FILE: hdl/timestamp_sorted_event_buffer_unit.sv
// ----------------------------------------------------------------------------
// timestamp_sorted_event_buffer_unit
// Event list kept in timestamp order in one dual-port memory. Other than appends,
// inserts find their place by binary search of memory reads, then move later ones up.
// ----------------------------------------------------------------------------
// Clear, full insert and unused op respond directly; a read fetches its entry.
//   Inserts into an empty list write at once; others check the last entry, then,
//   unless appending, search and move later entries, one access pair a cycle.
// One request at a time: the next is taken once the result is registered,
//   while that result may still wait on the sink.
// Synchronous reset empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
module timestamp_sorted_event_buffer_unit import tseb_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tseb_req_if.sink   req,
  tseb_rsp_if.source rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int DW = TIME_W + TAG_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LAST  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_RDATA = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]           state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        lo;
  logic [AW-1:0]        hi;
  logic [AW-1:0]        place;
  time_val_t            ev_time;
  logic [TAG_WIDTH-1:0] ev_tag;
  logic                 rd_ok;
  logic [STATUS_W-1:0]  res_status;
  time_val_t            res_time;
  logic [TAG_W-1:0]     res_tag;

  logic                 o_valid;
  logic [STATUS_W-1:0]  o_status;
  logic [COUNT_W-1:0]   o_count;
  time_val_t            o_time;
  logic [TAG_W-1:0]     o_tag;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [DW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [DW-1:0]        mem_rdata;

  time_val_t            rd_time;
  logic [TAG_WIDTH-1:0] rd_tag;
  logic [63:0]          rd_tag_wide;
  logic                 accept;
  logic [AW-1:0]        last_addr;
  logic                 probe_ge;
  logic [AW-1:0]        lo_next;
  logic [AW-1:0]        hi_next;
  logic [AW-1:0]        mid_next;
  logic [AW-1:0]        mid_first;

  assign rd_time     = mem_rdata[DW-1:TAG_WIDTH];
  assign rd_tag      = mem_rdata[TAG_WIDTH-1:0];
  assign rd_tag_wide = 64'(rd_tag);

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign last_addr = AW'(count - 1'b1);

  assign probe_ge  = (rd_time >= ev_time);
  assign lo_next   = probe_ge ? lo : AW'(ptr + 1'b1);
  assign hi_next   = probe_ge ? ptr : hi;
  assign mid_next  = AW'(({1'b0, lo_next} + {1'b0, hi_next}) >> 1);
  assign mid_first = AW'({1'b0, last_addr} >> 1);

  always_comb begin
    mem_raddr = ptr;
    if (state == S_IDLE) begin
      mem_raddr = (req.op == OP_READ) ? AW'(req.read_index) : last_addr;
    end else if (state == S_LAST) begin
      mem_raddr = (last_addr == '0) ? last_addr : mid_first;
    end else if (state == S_PROBE) begin
      mem_raddr = (lo_next < hi_next) ? mid_next : last_addr;
    end else if (state == S_SHIFT) begin
      mem_raddr = AW'(ptr - 1'b1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = place;
    mem_wdata = {ev_time, ev_tag};
    case (state)
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr + 1'b1);
        mem_wdata = mem_rdata;
      end
      S_PUT: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tseb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      o_valid <= 1'b0;
    end else begin
      if (state == S_RESP && (!o_valid || rsp.ready)) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ev_time    <= req.event_time;
            ev_tag     <= TAG_WIDTH'(64'(req.event_tag));
            res_status <= (req.op == OP_INSERT && count >= CW'(DEPTH)) ? ST_FULL : ST_OK;
            res_time   <= '0;
            res_tag    <= '0;
            rd_ok      <= (XW'(req.read_index) < XW'(count));
            case (req.op)
              OP_INSERT: begin
                if (count >= CW'(DEPTH)) begin
                  state <= S_RESP;
                end else if (count == '0) begin
                  place <= '0;
                  state <= S_PUT;
                end else begin
                  state <= S_LAST;
                end
              end
              OP_CLEAR: begin
                count <= '0;
                state <= S_RESP;
              end
              OP_READ: begin
                state <= S_RDATA;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_LAST: begin
          if (rd_time <= ev_time) begin
            place <= AW'(count);
            state <= S_PUT;
          end else if (last_addr == '0) begin
            place <= '0;
            ptr   <= last_addr;
            state <= S_SHIFT;
          end else begin
            lo    <= '0;
            hi    <= last_addr;
            ptr   <= mid_first;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          lo <= lo_next;
          hi <= hi_next;
          if (lo_next < hi_next) begin
            ptr <= mid_next;
          end else begin
            place <= lo_next;
            ptr   <= last_addr;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (ptr == place) begin
            state <= S_PUT;
          end else begin
            ptr <= AW'(ptr - 1'b1);
          end
        end
        S_PUT: begin
          count <= CW'(count + 1'b1);
          state <= S_RESP;
        end
        S_RDATA: begin
          if (rd_ok) begin
            res_time <= rd_time;
            res_tag  <= rd_tag_wide[TAG_W-1:0];
          end else begin
            res_status <= ST_BADIDX;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!o_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!o_valid || rsp.ready)) begin
      o_status <= res_status;
      o_count  <= COUNT_W'(count);
      o_time   <= res_time;
      o_tag    <= res_tag;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.entry_count = o_count;
  assign rsp.read_time   = o_time;
  assign rsp.read_tag    = o_tag;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> (lo <= ptr) && (ptr < hi))
    else $error("search probe outside window");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> (ptr >= place) && (XW'(ptr) < XW'(count)))
    else $error("entry move outside list");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |->
      (count == '0) || ($past(state) == S_PUT && count == $past(count) + 1'b1))
    else $error("entry count changed unexpectedly");

endmodule

FILE: hdl/tseb_mem.sv
// ----------------------------------------------------------------------------
// tseb_mem
// Simple dual-port entry store: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module tseb_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 96
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: test/tseb_checker.sv
// ----------------------------------------------------------------------------
// tseb_checker
// Watches the request and result channels of the event buffer. Keeps its own
// timestamp-ordered copy of the list, predicts the outcome of every accepted
// request and compares each result, field by field, with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module tseb_checker import tseb_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  tseb_req_if  req,
  tseb_rsp_if  rsp,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   full_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TAG_W-1:0] TAG_KEEP =
    (TAG_WIDTH >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((64'd1 << TAG_WIDTH) - 64'd1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    time_val_t           rtime;
    logic [TAG_W-1:0]    rtag;
  } outcome_t;

  time_val_t        slot_time [DEPTH];
  logic [TAG_W-1:0] slot_tag  [DEPTH];
  int               fill;
  outcome_t         outcome_q [$];

  function automatic outcome_t list_outcome(input logic [OP_W-1:0]    op,
                                            input time_val_t          t,
                                            input logic [TAG_W-1:0]   tag,
                                            input logic [INDEX_W-1:0] idx);
    outcome_t r;
    int       place;
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          place = fill;
          // lower bound: first entry not earlier than the new one
          if (fill != 0 && t < slot_time[fill-1]) begin
            for (int i = fill - 1; i >= 0; i--) begin
              if (slot_time[i] >= t) place = i;
            end
          end
          for (int k = fill; k > place; k--) begin
            slot_time[k] = slot_time[k-1];
            slot_tag[k]  = slot_tag[k-1];
          end
          slot_time[place] = t;
          slot_tag[place]  = tag & TAG_KEEP;
          fill++;
        end
      end
      OP_CLEAR: begin
        fill = 0;
      end
      OP_READ: begin
        if (int'(idx) < fill) begin
          r.rtime = slot_time[idx];
          r.rtag  = slot_tag[idx];
        end else begin
          r.status = ST_BADIDX;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  task automatic flag(input string field, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      fill      = 0;
      errors    = 0;
      pending   = 0;
      checked   = 0;
      full_hits = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d count %0d",
                   $time, rsp.status, rsp.entry_count);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          checked++;
          if (rsp.status !== want.status) flag("status", want.status, rsp.status);
          if (rsp.entry_count !== want.count) flag("entry_count", want.count, rsp.entry_count);
          if (rsp.read_time !== want.rtime) flag("read_time", want.rtime, rsp.read_time);
          if (rsp.read_tag !== want.rtag) flag("read_tag", want.rtag, rsp.read_tag);
        end
      end
      if (req.valid && req.ready) begin
        outcome_q.insert(outcome_q.size(),
                         list_outcome(req.op, req.event_time, req.event_tag,
                                      req.read_index));
      end
      pending = outcome_q.size();
    end
  end

endmodule

FILE: test/timestamp_sorted_event_buffer_unit_tb.sv
// ----------------------------------------------------------------------------
// timestamp_sorted_event_buffer_unit_tb
// Drives the event buffer with a directed run over the timestamp extremes,
// equal timestamps, reads in and out of range, clear and the spare op code,
// then with random phases that fill, read and clear the list, with random
// stalls on both channels. Results are checked by tseb_checker.
// ----------------------------------------------------------------------------
module timestamp_sorted_event_buffer_unit_tb import tseb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              DEPTH        = DEPTH_DEF;
  localparam int              RANDOM_ITEMS = 1280;
  localparam int              CALM_TAIL    = 150;
  localparam int              SETTLE       = 200;
  localparam int              LIMIT_NS     = 10_000_000;
  localparam logic [OP_W-1:0] OP_SPARE     = 2'd3;
  localparam time_val_t       TIME_MIN     = {1'b1, 63'd0};
  localparam time_val_t       TIME_MAX     = {1'b0, {63{1'b1}}};

  logic clk;
  logic rst;
  bit   calm       = 1'b0;
  int   gap_rate   = 0;
  int   stall_rate = 0;
  int   stall_left = 0;
  int   op_sent [4];
  int   fail_count;
  int   in_flight;
  int   checked_count;
  int   full_count;

  tseb_req_if req_ch ();
  tseb_rsp_if rsp_ch ();

  timestamp_sorted_event_buffer_unit #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH_DEF)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  tseb_checker #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH_DEF)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .errors    (fail_count),
    .pending   (in_flight),
    .checked   (checked_count),
    .full_hits (full_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && stall_rate != 0 && $urandom_range(1, 16) <= stall_rate) begin
      stall_left = $urandom_range(0, 7);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timestamp_sorted_event_buffer_unit test failed");
    $finish;
  end

  task automatic send(input logic [OP_W-1:0]    op,
                      input time_val_t          t,
                      input logic [TAG_W-1:0]   tag,
                      input logic [INDEX_W-1:0] idx);
    if (!calm && gap_rate != 0 && $urandom_range(1, 16) <= gap_rate) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.event_time <= t;
    req_ch.event_tag  <= tag;
    req_ch.read_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    op_sent[op]++;
    @(negedge clk);
  endtask

  function automatic time_val_t pick_time();
    int near;
    near = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return time_val_t'(near);
      4:          return TIME_MIN;
      5:          return TIME_MAX;
      6:          return time_val_t'(near) <<< 40;
      default:    return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    int               sent;
    int               span;
    int               style;
    int               roll;
    logic [OP_W-1:0]  op;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_INSERT;
    req_ch.event_time = '0;
    req_ch.event_tag  = '0;
    req_ch.read_index = '0;
    op_sent           = '{default: 0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gap_rate   = 4;
    stall_rate = 4;
    send(OP_READ, '0, '0, 6'd0);
    send(OP_READ, TIME_MAX, '1, 6'd63);
    send(OP_SPARE, '0, '0, 6'd0);
    send(OP_INSERT, '0, 32'h0000_0000, 6'd0);
    send(OP_INSERT, TIME_MAX, 32'hFFFF_FFFF, 6'd63);
    send(OP_INSERT, TIME_MIN, 32'hA5A5_5A5A, 6'd0);
    send(OP_INSERT, '0, 32'h0000_0001, 6'd0);          // equal, lands before the older zero
    send(OP_INSERT, TIME_MAX, 32'h0000_0002, 6'd0);    // equal to last, appended
    send(OP_INSERT, -64'sd1, 32'h0000_0003, 6'd0);
    for (int i = 0; i <= 6; i++) send(OP_READ, '0, '0, INDEX_W'(i));
    send(OP_SPARE, TIME_MIN, '1, 6'd63);
    send(OP_READ, '0, '0, 6'd63);
    send(OP_CLEAR, TIME_MAX, '1, 6'd63);
    send(OP_READ, '0, '0, 6'd0);
    send(OP_INSERT, 64'sd5, 32'h5A5A_A5A5, 6'd0);
    send(OP_READ, '0, '0, 6'd0);
    send(OP_CLEAR, '0, '0, 6'd0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      style      = $urandom_range(0, 9);
      span       = $urandom_range(40, 160);
      gap_rate   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      stall_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      for (int n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
        calm = (sent >= RANDOM_ITEMS - CALM_TAIL);
        roll = $urandom_range(0, 99);
        if (style <= 3) begin
          op = (roll < 92) ? OP_INSERT : (roll < 99) ? OP_READ : OP_CLEAR;
        end else if (style <= 6) begin
          op = (roll < 55) ? OP_INSERT : (roll < 97) ? OP_READ :
               (roll < 99) ? OP_SPARE : OP_CLEAR;
        end else if (style <= 8) begin
          op = (roll < 15) ? OP_INSERT : (roll < 97) ? OP_READ :
               (roll < 99) ? OP_SPARE : OP_CLEAR;
        end else begin
          op = OP_W'($urandom_range(0, 3));
        end
        send(op, pick_time(), $urandom, INDEX_W'($urandom_range(0, 63)));
        sent++;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        send(OP_CLEAR, pick_time(), $urandom, INDEX_W'($urandom_range(0, 63)));
        sent++;
      end
    end
    req_ch.valid <= 1'b0;

    while (in_flight != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Requests sent: %0d inserts, %0d clears, %0d reads, %0d spare op",
             op_sent[OP_INSERT], op_sent[OP_CLEAR], op_sent[OP_READ], op_sent[OP_SPARE]);
    $display("Results checked: %0d, inserts refused on a full list: %0d",
             checked_count, full_count);
    if (fail_count == 0) begin
      $display("timestamp_sorted_event_buffer_unit test passed");
    end else begin
      $display("timestamp_sorted_event_buffer_unit test failed");
    end
    $finish;
  end

endmodule
